// ----- sv/rpu_pkg.sv -----
// Shared types and constants for the raw10 pixel unpacker.
// Used by the front, queue, back and top-level modules; depends on nothing.
package rpu_pkg;

  // Clamp limits for the frame geometry registers.
  localparam int unsigned MaxWidth    = 8192;
  localparam int unsigned MaxHeight   = 8192;
  localparam int unsigned MaxRowBytes = 16384;

  // Default depth of the group queue between the front and back parts.
  localparam int unsigned QueueDepth = 4;

  // Configuration register indexes.
  localparam logic [2:0] RegPackMode    = 3'd0;
  localparam logic [2:0] RegMsbShift    = 3'd1;
  localparam logic [2:0] RegFrameWidth  = 3'd2;
  localparam logic [2:0] RegFrameHeight = 3'd3;
  localparam logic [2:0] RegRowBytes    = 3'd4;

  // Packing modes.
  localparam logic [1:0] ModeMipi      = 2'd0;
  localparam logic [1:0] ModeBitstream = 2'd1;
  localparam logic [1:0] ModeLsb       = 2'd2;
  localparam logic [1:0] ModeMsb       = 2'd3;

  // Configuration register set.
  typedef struct packed {
    logic [1:0]  pack_mode;
    logic [3:0]  msb_shift;
    logic [13:0] frame_width;
    logic [13:0] frame_height;
    logic [14:0] row_bytes;
  } cfg_t;

  // One completed byte group: up to four pixels, already marked.
  typedef struct packed {
    logic [3:0][15:0] px;
    logic [3:0][12:0] col;
    logic [3:0]       rend;
    logic [3:0]       fend;
    logic [3:0]       vld;
    logic [12:0]      row;
  } group_t;

endpackage

// ----- sv/rpu_front.sv -----
// Front part of the raw10 pixel unpacker: gathers bytes into groups, tracks
// row position and builds marked pixel groups. Depends on rpu_pkg.
module rpu_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rpu_pkg::cfg_t  cfg_i,
  input  logic [7:0]     byte_i,
  input  logic           accept_i,
  output logic           push_o,
  output rpu_pkg::group_t group_o
);
  import rpu_pkg::*;

  localparam logic [13:0] OcolMax = '1;

  logic [3:0][7:0] held_q;
  logic [2:0]      phase_q;
  logic [14:0]     bcol_q;
  logic [13:0]     ocol_q;
  logic [12:0]     row_q;

  logic [3:0]       sh;
  logic [13:0]      fw;
  logic [13:0]      fw_m1;
  logic [13:0]      fh;
  logic [13:0]      fh_m1;
  logic [14:0]      rb;
  logic [14:0]      rb_m1;
  logic             wide_mode;
  logic             complete;
  logic             row_last;
  logic             row_hit;
  logic [3:0][15:0] px;
  logic [3:0][14:0] col_w;
  logic [14:0]      ocol_sum;
  logic [13:0]      ocol_sat;

  // Clamp the geometry registers and decode the group size.
  always_comb begin
    sh = (cfg_i.msb_shift > 4'd8) ? 4'd8 : cfg_i.msb_shift;
    if (cfg_i.frame_width == '0) begin
      fw = 14'd1;
    end else if (cfg_i.frame_width > 14'(MaxWidth)) begin
      fw = 14'(MaxWidth);
    end else begin
      fw = cfg_i.frame_width;
    end
    if (cfg_i.frame_height == '0) begin
      fh = 14'd1;
    end else if (cfg_i.frame_height > 14'(MaxHeight)) begin
      fh = 14'(MaxHeight);
    end else begin
      fh = cfg_i.frame_height;
    end
    if (cfg_i.row_bytes < 15'd2) begin
      rb = 15'd2;
    end else if (cfg_i.row_bytes > 15'(MaxRowBytes)) begin
      rb = 15'(MaxRowBytes);
    end else begin
      rb = cfg_i.row_bytes;
    end
    fw_m1     = fw - 14'd1;
    fh_m1     = fh - 14'd1;
    rb_m1     = rb - 15'd1;
    wide_mode = (cfg_i.pack_mode == ModeMipi) || (cfg_i.pack_mode == ModeBitstream);
    complete  = phase_q >= (wide_mode ? 3'd4 : 3'd1);
    row_last  = bcol_q >= rb_m1;
    row_hit   = {1'b0, row_q} == fh_m1;
  end

  // Unpack the held bytes and the incoming byte into pixel values.
  always_comb begin
    px = '0;
    case (cfg_i.pack_mode)
      ModeMipi: begin
        for (int i = 0; i < 4; i++) begin
          px[i] = ({8'h00, held_q[i]} << sh) | {14'd0, byte_i[2*i +: 2]};
        end
      end
      ModeBitstream: begin
        px[0] = {6'd0, held_q[1][1:0], held_q[0]};
        px[1] = {6'd0, held_q[2][3:0], held_q[1][7:2]};
        px[2] = {6'd0, held_q[3][5:0], held_q[2][7:4]};
        px[3] = {6'd0, byte_i, held_q[3][7:6]};
      end
      ModeLsb: begin
        px[0] = {6'd0, byte_i[1:0], held_q[0]};
      end
      default: begin
        px[0] = ({8'h00, held_q[0]} >> (4'd8 - sh)) | ({8'h00, byte_i} << sh);
      end
    endcase
  end

  // Mark each pixel position with its column, validity and end flags.
  always_comb begin
    group_o.px  = px;
    group_o.row = row_q;
    for (int i = 0; i < 4; i++) begin
      col_w[i]        = {1'b0, ocol_q} + 15'(i);
      group_o.col[i]  = col_w[i][12:0];
      group_o.vld[i]  = (wide_mode || (i == 0)) && (col_w[i] < {1'b0, fw});
      group_o.rend[i] = col_w[i] == {1'b0, fw_m1};
      group_o.fend[i] = (col_w[i] == {1'b0, fw_m1}) && row_hit;
    end
    ocol_sum = {1'b0, ocol_q} + (wide_mode ? 15'd4 : 15'd1);
    ocol_sat = (ocol_sum > {1'b0, OcolMax}) ? OcolMax : ocol_sum[13:0];
    push_o   = accept_i && complete && (group_o.vld != '0);
  end

  // Group phase, byte column, pixel column and row counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      phase_q <= '0;
      bcol_q  <= '0;
      ocol_q  <= '0;
      row_q   <= '0;
    end else if (accept_i) begin
      if (complete) begin
        ocol_q  <= ocol_sat;
        phase_q <= '0;
      end else begin
        held_q[phase_q[1:0]] <= byte_i;
        phase_q              <= phase_q + 3'd1;
      end
      if (row_last) begin
        bcol_q  <= '0;
        ocol_q  <= '0;
        phase_q <= '0;
        row_q   <= ({1'b0, row_q} >= fh_m1) ? '0 : row_q + 13'd1;
      end else begin
        bcol_q <= bcol_q + 15'd1;
      end
    end
  end

  // Valid lanes of a pushed group always form a prefix starting at lane zero.
  a_vld_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (group_o.vld == 4'b0001) || (group_o.vld == 4'b0011) ||
               (group_o.vld == 4'b0111) || (group_o.vld == 4'b1111))
    else $error("pushed group has a gap in its valid lanes");

endmodule

// ----- sv/rpu_queue.sv -----
// Short queue of pixel groups between the front and back parts of the unpacker.
// Depends on rpu_pkg for the group type.
module rpu_queue #(
  parameter int unsigned Depth = rpu_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rpu_pkg::group_t data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output rpu_pkg::group_t data_o
);
  import rpu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  group_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage is written at the tail only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("group queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("group queue read while empty");

endmodule

// ----- sv/rpu_back.sv -----
// Back part of the unpacker: walks the valid lanes of the head group and
// delivers one pixel per request through an output register. Depends on rpu_pkg.
module rpu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  rpu_pkg::group_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     out_pixel_o,
  output logic [12:0]     out_col_o,
  output logic [12:0]     out_row_o,
  output logic            out_rend_o,
  output logic            out_fend_o
);
  import rpu_pkg::*;

  logic [3:0]  done_q;
  logic        out_valid_q;
  logic [15:0] pixel_q;
  logic [12:0] col_q;
  logic [12:0] row_q;
  logic        rend_q;
  logic        fend_q;

  logic [3:0] rem;
  logic [1:0] lane;
  logic [3:0] sel;
  logic       last;
  logic       adv;

  // Pick the lowest lane not yet delivered from the head group.
  always_comb begin
    rem  = head_i.vld & ~done_q;
    lane = '0;
    for (int i = 3; i >= 0; i--) begin
      if (rem[i]) begin
        lane = 2'(i);
      end
    end
    sel   = 4'b0001 << lane;
    last  = (rem & ~sel) == '0;
    adv   = head_valid_i && (!out_valid_q || out_ready_i);
    pop_o = adv && last;
  end

  // Lane bookkeeping and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
      done_q      <= last ? '0 : (done_q | sel);
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pixel_q <= head_i.px[lane];
      col_q   <= head_i.col[lane];
      row_q   <= head_i.row;
      rend_q  <= head_i.rend[lane];
      fend_q  <= head_i.fend[lane];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = pixel_q;
  assign out_col_o   = col_q;
  assign out_row_o   = row_q;
  assign out_rend_o  = rend_q;
  assign out_fend_o  = fend_q;

  // A group at the head always has a lane left to deliver.
  a_head_has_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> rem != '0)
    else $error("head group has no lane left but was not popped");

endmodule

// ----- sv/raw10_pixel_unpacker_unit.sv -----
// Raw sensor byte unpacker. It takes one byte per cycle on the slave stream while
// s_axis_tready is high, in any of the four packing modes, and delivers one pixel per
// cycle on the master stream while m_axis_tready is high. A group of bytes is unpacked
// in the cycle its last byte arrives and placed in a queue of QueueDepth groups; the
// back part delivers the group's pixels one per cycle from the queue head through its
// output register. Since a group of five bytes gives at most four pixels, and a group
// of two bytes one, the output keeps up with a continuous byte stream while
// m_axis_tready stays high; s_axis_tready falls only while the queue is full.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i and
// takes effect on the next byte. No clearing pass is needed after reset.
module raw10_pixel_unpacker_unit #(
  parameter int unsigned QueueDepth = rpu_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [14:0] cfg_wdata_i,
  // Byte input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  // Pixel output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // pixel[15:0], pixel_col[28:16], pixel_row[41:29], zero
  output logic        m_axis_tlast,   // row_end
  output logic [0:0]  m_axis_tuser    // frame_end
);
  import rpu_pkg::*;

  cfg_t   cfg_q;
  group_t front_group;
  group_t head_group;
  logic   accept;
  logic   push;
  logic   pop;
  logic   full;
  logic   head_valid;
  logic [15:0] out_pixel;
  logic [12:0] out_col;
  logic [12:0] out_row;
  logic        out_rend;
  logic        out_fend;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pack_mode    <= ModeMipi;
      cfg_q.msb_shift    <= 4'd2;
      cfg_q.frame_width  <= 14'd640;
      cfg_q.frame_height <= 14'd480;
      cfg_q.row_bytes    <= 15'd800;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPackMode:    cfg_q.pack_mode    <= cfg_wdata_i[1:0];
        RegMsbShift:    cfg_q.msb_shift    <= cfg_wdata_i[3:0];
        RegFrameWidth:  cfg_q.frame_width  <= cfg_wdata_i[13:0];
        RegFrameHeight: cfg_q.frame_height <= cfg_wdata_i[13:0];
        RegRowBytes:    cfg_q.row_bytes    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Bytes are taken whenever the queue has room for a group.
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rpu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .byte_i   (s_axis_tdata),
    .accept_i (accept),
    .push_o   (push),
    .group_o  (front_group)
  );

  rpu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_group),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .data_o  (head_group)
  );

  rpu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_group),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_pixel_o  (out_pixel),
    .out_col_o    (out_col),
    .out_row_o    (out_row),
    .out_rend_o   (out_rend),
    .out_fend_o   (out_fend)
  );

  // Pack the result fields onto the output stream.
  assign m_axis_tdata = {6'd0, out_row, out_col, out_pixel};
  assign m_axis_tlast = out_rend;
  assign m_axis_tuser = out_fend;

endmodule

// ----- sim/rpu_pixel_checker.sv -----
// Scoreboard for the raw10 pixel unpacker: tracks register writes and accepted bytes,
// predicts the pixels each byte releases and compares them with the pixel stream.
// Depends on rpu_pkg for the register set, register indexes and packing modes.
`timescale 1ns / 1ps

module rpu_pixel_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes as seen by the block.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [14:0] cfg_wdata_i,
  // Byte stream.
  input  logic        byte_valid_i,
  input  logic        byte_ready_i,
  input  logic [7:0]  byte_i,
  // Pixel stream.
  input  logic        pix_valid_i,
  input  logic        pix_ready_i,
  input  logic [47:0] pix_data_i,   // pixel[15:0], pixel_col[28:16], pixel_row[41:29], zero
  input  logic        pix_last_i,   // row_end
  input  logic [0:0]  pix_user_i,   // frame_end
  output int unsigned mismatches_o,
  output int unsigned pending_o
);
  import rpu_pkg::*;

  localparam int unsigned OutColMax = 16383;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [15:0] pixel;
    logic [12:0] col;
    logic [12:0] row;
    logic        row_end;
    logic        frame_end;
  } pixel_t;

  // Register copy and unpacker state.
  cfg_t        regs;
  logic [7:0]  held [4];
  logic [2:0]  group_phase;
  logic [14:0] byte_col;
  logic [13:0] out_col;
  logic [12:0] row_count;

  pixel_t      pending_pixels [$];
  int unsigned mismatch_count;

  // Advance the unpacker by one byte and queue the pixels it releases.
  task automatic unpack_byte(input logic [7:0] b);
    int unsigned fw, fh, rb, sh, gsize, n, col, bv;
    int unsigned h [4];
    int unsigned px [4];
    pixel_t      res;
    bv = b;
    fw = (regs.frame_width == 0) ? 1 :
         ((regs.frame_width > MaxWidth) ? MaxWidth : regs.frame_width);
    fh = (regs.frame_height == 0) ? 1 :
         ((regs.frame_height > MaxHeight) ? MaxHeight : regs.frame_height);
    rb = (regs.row_bytes < 2) ? 2 :
         ((regs.row_bytes > MaxRowBytes) ? MaxRowBytes : regs.row_bytes);
    sh = (regs.msb_shift > 8) ? 8 : regs.msb_shift;
    gsize = (regs.pack_mode == ModeMipi || regs.pack_mode == ModeBitstream) ? 5 : 2;

    if (group_phase >= gsize - 1) begin
      // The group is complete: this byte and the held ones give the pixels.
      for (int i = 0; i < 4; i++) h[i] = held[i];
      n = 4;
      case (regs.pack_mode)
        ModeMipi: begin
          for (int i = 0; i < 4; i++) px[i] = (h[i] << sh) | ((bv >> (2 * i)) & 3);
        end
        ModeBitstream: begin
          px[0] = h[0] | ((h[1] & 'h03) << 8);
          px[1] = (h[1] >> 2) | ((h[2] & 'h0f) << 6);
          px[2] = (h[2] >> 4) | ((h[3] & 'h3f) << 4);
          px[3] = (h[3] >> 6) | (bv << 2);
        end
        ModeLsb: begin
          px[0] = h[0] | ((bv & 3) << 8);
          n = 1;
        end
        default: begin
          px[0] = (h[0] >> (8 - sh)) | (bv << sh);
          n = 1;
        end
      endcase
      // Positions past the frame width are dropped one by one.
      for (int i = 0; i < n; i++) begin
        col = out_col + i;
        if (col < fw) begin
          res.pixel     = px[i][15:0];
          res.col       = col[12:0];
          res.row       = row_count;
          res.row_end   = (col == fw - 1);
          res.frame_end = res.row_end && (row_count == fh - 1);
          pending_pixels.push_back(res);
        end
      end
      col = out_col + n;
      out_col = (col > OutColMax) ? OutColMax[13:0] : col[13:0];
      group_phase = '0;
    end else begin
      held[group_phase[1:0]] = b;
      group_phase = group_phase + 3'd1;
    end

    // End of the padded row: a partial group is thrown away.
    if (byte_col >= rb - 1) begin
      byte_col    = '0;
      out_col     = '0;
      group_phase = '0;
      if (row_count >= fh - 1) row_count = '0;
      else row_count = row_count + 13'd1;
    end else begin
      byte_col = byte_col + 15'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_t got;
    pixel_t want;
    if (!rst_ni) begin
      regs.pack_mode    = ModeMipi;
      regs.msb_shift    = 4'd2;
      regs.frame_width  = 14'd640;
      regs.frame_height = 14'd480;
      regs.row_bytes    = 15'd800;
      for (int i = 0; i < 4; i++) held[i] = '0;
      group_phase    = '0;
      byte_col       = '0;
      out_col        = '0;
      row_count      = '0;
      mismatch_count = 0;
      pending_pixels.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      // Register writes land before any byte of the same cycle.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPackMode:    regs.pack_mode    = cfg_wdata_i[1:0];
          RegMsbShift:    regs.msb_shift    = cfg_wdata_i[3:0];
          RegFrameWidth:  regs.frame_width  = cfg_wdata_i[13:0];
          RegFrameHeight: regs.frame_height = cfg_wdata_i[13:0];
          RegRowBytes:    regs.row_bytes    = cfg_wdata_i[14:0];
          default: ;
        endcase
      end

      if (byte_valid_i && byte_ready_i) unpack_byte(byte_i);

      // Each delivered pixel is matched against the oldest prediction.
      if (pix_valid_i && pix_ready_i) begin
        got.pixel     = pix_data_i[15:0];
        got.col       = pix_data_i[28:16];
        got.row       = pix_data_i[41:29];
        got.row_end   = pix_last_i;
        got.frame_end = pix_user_i[0];
        if (pending_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("%t: unexpected pixel %h col %0d row %0d row_end %b frame_end %b",
                     $time, got.pixel, got.col, got.row, got.row_end, got.frame_end);
        end else begin
          want = pending_pixels.pop_front();
          if (got.pixel !== want.pixel || got.col !== want.col || got.row !== want.row ||
              got.row_end !== want.row_end || got.frame_end !== want.frame_end) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
              $display("%t: pixel mismatch, expected %h/%0d/%0d/%b/%b, got %h/%0d/%0d/%b/%b",
                       $time, want.pixel, want.col, want.row, want.row_end, want.frame_end,
                       got.pixel, got.col, got.row, got.row_end, got.frame_end);
          end
        end
      end

      mismatches_o <= mismatch_count;
      pending_o    <= pending_pixels.size();
    end
  end

endmodule

// ----- sim/raw10_pixel_unpacker_unit_test.sv -----
// Testbench top for raw10_pixel_unpacker_unit: drives register writes and the byte
// stream, stalls the pixel stream, and gives the verdict from rpu_pixel_checker.
// Depends on rpu_pkg, raw10_pixel_unpacker_unit and rpu_pixel_checker.
`timescale 1ns / 1ps

module raw10_pixel_unpacker_unit_test;
  import rpu_pkg::*;

  localparam int unsigned RandomBytes  = 470;
  localparam int unsigned SettleCycles = 8;
  localparam logic [2:0]  FirstSpareReg = 3'd5;

  typedef enum logic [1:0] {ReadyAlways, ReadyHalf, ReadySparse, ReadyNone} drain_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [14:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned burst_left;
  int unsigned stall_left;
  drain_mode_e drain_mode;

  raw10_pixel_unpacker_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  rpu_pixel_checker pixel_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_i (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .pix_valid_i  (m_axis_tvalid),
    .pix_ready_i  (m_axis_tready),
    .pix_data_i   (m_axis_tdata),
    .pix_last_i   (m_axis_tlast),
    .pix_user_i   (m_axis_tuser),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pixel receiver: stretches of steady, patchy, sparse or no readiness.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      drain_mode = drain_mode_e'($urandom_range(0, 3));
      stall_left = (drain_mode == ReadyNone) ? $urandom_range(1, 12) : $urandom_range(1, 48);
    end else begin
      stall_left--;
    end
    case (drain_mode)
      ReadyAlways: m_axis_tready <= 1'b1;
      ReadyHalf:   m_axis_tready <= ($urandom_range(0, 1) == 0);
      ReadySparse: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:     m_axis_tready <= 1'b0;
    endcase
  end

  // Offer one byte and wait for its request to be taken; bursts are broken by gaps.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop sending until every predicted pixel is out, then let the pipeline settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [14:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Write the whole register set once the block is idle, plus one unused index.
  task automatic set_config(input logic [1:0] mode, input logic [3:0] shift,
                            input logic [13:0] fw, input logic [13:0] fh,
                            input logic [14:0] rb);
    wait_idle();
    write_reg(RegPackMode, {13'd0, mode});
    write_reg(RegMsbShift, {11'd0, shift});
    write_reg(RegFrameWidth, {1'b0, fw});
    write_reg(RegFrameHeight, {1'b0, fh});
    write_reg(RegRowBytes, rb);
    write_reg(FirstSpareReg + 3'($urandom_range(0, 2)), 15'($urandom_range(0, 32767)));
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned random_sent, groups, per_group, gsize, nbytes, pause_at, rb_eff, fh_eff;
    logic [1:0]  mode;
    logic [3:0]  shift;
    logic [13:0] fw;
    logic [13:0] fh;
    logic [14:0] rb;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    burst_left    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, MIPI packing: extremes of the low bits and a partial group.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'hE4);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);

    // Change mid-row to MSB words with every register out of range: the held bytes
    // complete a group at once, the same byte ends the row and the row wraps.
    set_config(ModeMsb, 4'd15, 14'd0, 14'd0, 15'd1);
    send_byte(8'hC3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h3C);
    send_byte(8'h81);

    // Bitstream packing with a short row and a partial group dropped at the row end.
    set_config(ModeBitstream, 4'd8, 14'd5, 14'd2, 15'd7);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h12);
    send_byte(8'h34);

    // LSB words with the width, height and stride above their limits.
    set_config(ModeLsb, 4'd0, 14'h3FFF, 14'h3FFF, 15'h7FFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h03);

    // Random phases: mostly whole rows and frames in small geometries, some cut short.
    random_sent = 0;
    while (random_sent < RandomBytes) begin
      mode      = 2'($urandom_range(0, 3));
      gsize     = (mode == ModeMipi || mode == ModeBitstream) ? 5 : 2;
      per_group = (gsize == 5) ? 4 : 1;
      groups    = $urandom_range(1, 6);
      shift     = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15)) :
                                                4'($urandom_range(0, 8));
      rb = 15'(groups * gsize + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0));
      if ($urandom_range(0, 11) == 0) rb = 15'($urandom_range(0, 1));
      else if ($urandom_range(0, 11) == 0) rb = 15'($urandom_range(16385, 32767));
      case ($urandom_range(0, 5))
        0, 1, 2: fw = 14'(groups * per_group);
        3:       fw = 14'($urandom_range(1, groups * per_group + 4));
        4:       fw = '0;
        default: fw = 14'($urandom_range(8193, 16383));
      endcase
      if ($urandom_range(0, 9) == 0) fh = ($urandom_range(0, 1) == 0) ? 14'd0 : 14'h3FFF;
      else fh = 14'($urandom_range(1, 4));

      rb_eff = (rb < 2) ? 2 : ((rb > MaxRowBytes) ? MaxRowBytes : rb);
      fh_eff = (fh == 0) ? 1 : ((fh > 4) ? 4 : fh);
      nbytes = rb_eff * $urandom_range(1, fh_eff + 1);
      if (nbytes > 150) nbytes = 150;
      if ($urandom_range(0, 4) == 0) nbytes = $urandom_range(1, 30);
      if (nbytes > RandomBytes - random_sent) nbytes = RandomBytes - random_sent;
      pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, nbytes) : 0;

      set_config(mode, shift, fw, fh, rb);
      for (int k = 1; k <= nbytes; k++) begin
        send_byte(8'($urandom_range(0, 255)));
        if (k == pause_at) wait_idle();
      end
      random_sent += nbytes;
    end

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rpu_pkg.sv
sv/rpu_front.sv
sv/rpu_queue.sv
sv/rpu_back.sv
sv/raw10_pixel_unpacker_unit.sv
sim/rpu_pixel_checker.sv
sim/raw10_pixel_unpacker_unit_test.sv
